FILE: sv/srpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_pkg
// shared constants, sequencer states and lane control word for the stereo
// mean-square and peak envelope follower
// ----------------------------------------------------------------------------
package srpe_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 16;

   // register index port is one bit wider than needed so stray indexes decode
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_RMS_ATTACK   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RMS_RELEASE  = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PEAK_ATTACK  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PEAK_RELEASE = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MULT,
      ST_UPDATE
   } srpe_state_type;

   typedef struct packed {
      logic load;    // capture a new frame
      logic diff;    // compare and take the distance
      logic mult;    // coefficient multiply
      logic update;  // write back the new levels
   } srpe_ctrl_type;

endpackage

FILE: sv/srpe_follow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_follow
// one-pole attack/release follower: level = new + k*(level - new), rounded
// toward minus infinity, over three sequenced steps
// ----------------------------------------------------------------------------
module srpe_follow
   import srpe_pkg::*;
#(
   parameter int VALUE_BITS = 31,
   parameter int COEF_BITS  = COEF_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  srpe_ctrl_type         ctrl,
   input  logic [VALUE_BITS-1:0] new_value,
   input  logic [COEF_BITS-1:0]  attack_coef,
   input  logic [COEF_BITS-1:0]  release_coef,
   output logic [VALUE_BITS-1:0] level
);

   localparam int PROD_BITS = VALUE_BITS + COEF_BITS;

   logic [VALUE_BITS-1:0] level_ff, level_in;
   logic [VALUE_BITS-1:0] dist_ff, dist_in;
   logic                  below_ff, below_in;
   logic [COEF_BITS-1:0]  coef_ff, coef_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [VALUE_BITS-1:0] prod_hi;
   logic                  prod_frac;

   always_comb begin
      below_in = new_value < level_ff;
      dist_in  = below_in ? level_ff - new_value : new_value - level_ff;
      coef_in  = below_in ? release_coef : attack_coef;
      prod_in  = PROD_BITS'(coef_ff) * PROD_BITS'(dist_ff);
   end

   // falling: floor of the product; rising: subtract its ceiling
   assign prod_hi   = prod_ff[PROD_BITS-1:COEF_BITS];
   assign prod_frac = |prod_ff[COEF_BITS-1:0];

   always_comb begin
      if (below_ff) begin
         level_in = new_value + prod_hi;
      end else begin
         level_in = new_value - prod_hi - VALUE_BITS'(prod_frac);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.diff) begin
         dist_ff  <= dist_in;
         below_ff <= below_in;
         coef_ff  <= coef_in;
      end
      if (ctrl.mult) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (ctrl.update) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

FILE: sv/srpe_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpe_lane
// one audio channel: square and magnitude of the sample, then the
// mean-square and peak followers side by side
// ----------------------------------------------------------------------------
module srpe_lane
   import srpe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  srpe_ctrl_type              ctrl,
   input  logic [SAMPLE_BITS-1:0]     sample,
   input  logic [COEF_BITS-1:0]       rms_attack_coef,
   input  logic [COEF_BITS-1:0]       rms_release_coef,
   input  logic [COEF_BITS-1:0]       peak_attack_coef,
   input  logic [COEF_BITS-1:0]       peak_release_coef,
   output logic [2*SAMPLE_BITS-2:0]   mean_square,
   output logic [SAMPLE_BITS-1:0]     peak
);

   localparam int SQ_BITS = 2 * SAMPLE_BITS - 1;

   logic [SQ_BITS-1:0]       square_ff, square_in;
   logic [SAMPLE_BITS-1:0]   mag_ff, mag_in;
   logic signed [2*SAMPLE_BITS-1:0] square_full;

   // signed square is never negative and at most 2^(2*SAMPLE_BITS-2)
   assign square_full = $signed(sample) * $signed(sample);
   assign square_in   = square_full[SQ_BITS-1:0];
   // full-scale negative maps to 2^(SAMPLE_BITS-1), which still fits unsigned
   assign mag_in      = sample[SAMPLE_BITS-1] ? (~sample) + 1'b1 : sample;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         square_ff <= square_in;
         mag_ff    <= mag_in;
      end
   end

   srpe_follow #(
      .VALUE_BITS (SQ_BITS),
      .COEF_BITS  (COEF_BITS)
   ) u_rms (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .new_value    (square_ff),
      .attack_coef  (rms_attack_coef),
      .release_coef (rms_release_coef),
      .level        (mean_square)
   );

   srpe_follow #(
      .VALUE_BITS (SAMPLE_BITS),
      .COEF_BITS  (COEF_BITS)
   ) u_peak (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .new_value    (mag_ff),
      .attack_coef  (peak_attack_coef),
      .release_coef (peak_release_coef),
      .level        (peak)
   );

endmodule

FILE: sv/stereo_rms_peak_envelope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_rms_peak_envelope
// stereo mean-square and peak envelope follower with attack/release smoothing
// ----------------------------------------------------------------------------
// flow: an accepted frame word is captured, compared, multiplied and written
//   back into the levels, which registers rsp_tvalid; write-back waits until
//   rsp_tready takes any held result word; the compare, coefficient multiply
//   and write-back steps of each follower run in sequence on one frame at a time
// reset: synchronous, active high; clears all levels, coefficients and the
//   sequencer; coefficients at zero make every level track its input exactly
// ----------------------------------------------------------------------------
module stereo_rms_peak_envelope
   import srpe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,

   // frame words in
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // left_sample, right_sample; zero padded to bytes
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,

   // level words out
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // left_mean_square, right_mean_square, left_peak, right_peak; zero padded
   output logic [((6*SAMPLE_BITS-2+7)/8)*8-1:0] rsp_tdata,

   // coefficient writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [COEF_BITS-1:0]       csr_wdata
);

   localparam int SQ_BITS    = 2 * SAMPLE_BITS - 1;
   localparam int LEVEL_BITS = 2 * SQ_BITS + 2 * SAMPLE_BITS;
   localparam int RSP_BITS   = ((LEVEL_BITS + 7) / 8) * 8;

   // ---------------------------------------------------------------------
   // coefficient registers, always writable; unknown indexes are dropped
   // ---------------------------------------------------------------------
   logic [COEF_BITS-1:0] rms_attack_ff, rms_release_ff;
   logic [COEF_BITS-1:0] peak_attack_ff, peak_release_ff;
   logic                 csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rms_attack_ff   <= '0;
         rms_release_ff  <= '0;
         peak_attack_ff  <= '0;
         peak_release_ff <= '0;
      end else if (csr_write) begin
         case (csr_addr)
            CSR_RMS_ATTACK:   rms_attack_ff   <= csr_wdata;
            CSR_RMS_RELEASE:  rms_release_ff  <= csr_wdata;
            CSR_PEAK_ATTACK:  peak_attack_ff  <= csr_wdata;
            CSR_PEAK_RELEASE: peak_release_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // sequencer: capture, compare, multiply, write back
   // ---------------------------------------------------------------------
   srpe_state_type state_ff, state_in;
   srpe_ctrl_type  ctrl;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // the output word may be replaced once it is taken or was never shown
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MULT;
         ST_MULT:   state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      ctrl        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.load  = req_tvalid;
         end
         ST_DIFF:   ctrl.diff   = 1'b1;
         ST_MULT:   ctrl.mult   = 1'b1;
         ST_UPDATE: ctrl.update = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (ctrl.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // channel lanes
   // ---------------------------------------------------------------------
   logic [SQ_BITS-1:0]     left_ms, right_ms;
   logic [SAMPLE_BITS-1:0] left_pk, right_pk;

   srpe_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_left (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .sample            (req_tdata[SAMPLE_BITS-1:0]),
      .rms_attack_coef   (rms_attack_ff),
      .rms_release_coef  (rms_release_ff),
      .peak_attack_coef  (peak_attack_ff),
      .peak_release_coef (peak_release_ff),
      .mean_square       (left_ms),
      .peak              (left_pk)
   );

   srpe_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_right (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .sample            (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .rms_attack_coef   (rms_attack_ff),
      .rms_release_coef  (rms_release_ff),
      .peak_attack_coef  (peak_attack_ff),
      .peak_release_coef (peak_release_ff),
      .mean_square       (right_ms),
      .peak              (right_pk)
   );

   // ---------------------------------------------------------------------
   // merge: lane levels hold until the next write back, which waits for
   // the output word to be taken, so they drive the result word directly
   // ---------------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({right_pk, left_pk, right_ms, left_ms});

endmodule

FILE: verif/stereo_rms_peak_envelope_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_rms_peak_envelope_test
// self-checking bench for the stereo mean-square and peak envelope follower:
// stereo frame words are fed from a queue, every level word is checked
// against an in-bench follower model, and the smoothing coefficients change
// between phases while the block is idle
// ----------------------------------------------------------------------------
module stereo_rms_peak_envelope_test;
   import srpe_pkg::*;

   localparam int CLOCK_HALF_NS = 4;
   localparam int RESET_CYCLES  = 10;
   // settle time after the last level word is out
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_FRAMES  = 119;

   localparam longint unsigned COEF_ROUND_UP = (64'd1 << COEF_BITS_DEF) - 64'd1;

   // write addresses above the last coefficient decode to nothing
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNMAPPED_FIRST = CSR_PEAK_RELEASE + 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNMAPPED_LAST  = '1;

   // back-pressure profiles, one per phase
   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   // one result word split into its level fields
   typedef struct packed {
      logic [30:0] left_mean_square;
      logic [30:0] right_mean_square;
      logic [15:0] left_peak;
      logic [15:0] right_peak;
   } level_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_ADDR_BITS-1:0] csr_addr = CSR_RMS_ATTACK;
   logic [COEF_BITS_DEF-1:0] csr_wdata = '0;

   // frame words waiting for the driver: right sample high, left sample low
   logic [31:0]    frames_pending [$];
   level_word_type level_words_due [$];
   logic [31:0]    frame_offered = '0;
   int             frames_queued = 0;
   int             frames_accepted = 0;
   flow_mode_type  flow_mode = FLOW_FREE;

   // bench copy of the follower state and coefficient registers
   logic [15:0] coef_shadow [0:3] = '{default: '0};
   logic [30:0] ms_level [0:1] = '{default: '0};
   logic [15:0] pk_level [0:1] = '{default: '0};

   int error_count = 0;
   int cycle_count = 0;

   stereo_rms_peak_envelope DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // one-pole step: attack when the new value is not below the level,
   // release otherwise; release product floored, attack product rounded up, so the level stays between the two
   function automatic longint unsigned track_level(longint unsigned level,
                                                   longint unsigned target,
                                                   longint unsigned k_attack,
                                                   longint unsigned k_release);
      if (target < level) return target + ((k_release * (level - target)) >> COEF_BITS_DEF);
      return target - ((k_attack * (target - level) + COEF_ROUND_UP) >> COEF_BITS_DEF);
   endfunction

   // advance both channels by one frame and queue the level word it yields
   function automatic void predict_levels(logic [31:0] frame);
      logic [15:0]     raw;
      longint unsigned mag;
      level_word_type  word;
      for (int ch = 0; ch < 2; ch++) begin
         raw = (ch == 0) ? frame[15:0] : frame[31:16];
         // full-scale negative gives 0x8000, which is still the right magnitude
         mag = raw[15] ? 64'(16'(~raw + 16'd1)) : 64'(raw);
         ms_level[ch] = 31'(track_level(ms_level[ch], mag * mag,
                                        coef_shadow[CSR_RMS_ATTACK],
                                        coef_shadow[CSR_RMS_RELEASE]));
         pk_level[ch] = 16'(track_level(pk_level[ch], mag,
                                        coef_shadow[CSR_PEAK_ATTACK],
                                        coef_shadow[CSR_PEAK_RELEASE]));
      end
      word.left_mean_square  = ms_level[0];
      word.right_mean_square = ms_level[1];
      word.left_peak         = pk_level[0];
      word.right_peak        = pk_level[1];
      level_words_due.push_back(word);
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         default: return 16'h8001;
      endcase
   endfunction

   // quiet content, roughly -256 .. 255
   function automatic logic [15:0] pick_quiet();
      return 16'($urandom_range(0, 511) - 256);
   endfunction

   // coefficient with a strong bias toward the two ends of the range
   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void queue_frame(logic [15:0] left, logic [15:0] right);
      frames_pending.push_back({right, left});
      frames_queued++;
   endfunction

   // ------------------------------------------------------------------------
   // frame driver: holds a word until it is taken, gaps only between words
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_levels(frame_offered);
            frames_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (frames_pending.size() > 0 &&
                !((flow_mode == FLOW_SENDER_GAPS && $urandom_range(0, 99) < 59) ||
                  (flow_mode == FLOW_BOTH && $urandom_range(0, 99) < 24))) begin
               frame_offered = frames_pending.pop_front();
               req_tdata  <= frame_offered;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // level monitor: compares every accepted word with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      level_word_type seen;
      level_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.left_mean_square  = rsp_tdata[30:0];
            seen.right_mean_square = rsp_tdata[61:31];
            seen.left_peak         = rsp_tdata[77:62];
            seen.right_peak        = rsp_tdata[93:78];
            if (level_words_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("level word with nothing due: ms %0d/%0d peak %0d/%0d",
                           seen.left_mean_square, seen.right_mean_square,
                           seen.left_peak, seen.right_peak);
            end else begin
               want = level_words_due.pop_front();
               if (seen != want) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display(
                        "level word differs: ms %0d/%0d pk %0d/%0d, got ms %0d/%0d pk %0d/%0d",
                        want.left_mean_square, want.right_mean_square,
                        want.left_peak, want.right_peak,
                        seen.left_mean_square, seen.right_mean_square,
                        seen.left_peak, seen.right_peak);
               end
            end
         end
         rsp_tready <= !((flow_mode == FLOW_RECEIVER_STALLS && $urandom_range(0, 99) < 59) ||
                         (flow_mode == FLOW_BOTH && $urandom_range(0, 99) < 24));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stereo_rms_peak_envelope: mismatch");
         $finish;
      end
   end

   // one register write; the bench copy follows only the mapped indexes
   task automatic write_coef(logic [CSR_ADDR_BITS-1:0] addr, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (addr <= CSR_PEAK_RELEASE) coef_shadow[addr] = value;
      csr_valid <= 1'b0;
   endtask

   // all four coefficients plus a stray write that must change nothing
   task automatic set_coefs(logic [15:0] rms_att, logic [15:0] rms_rel,
                            logic [15:0] pk_att, logic [15:0] pk_rel);
      write_coef(CSR_RMS_ATTACK, rms_att);
      write_coef(CSR_RMS_RELEASE, rms_rel);
      write_coef(CSR_PEAK_ATTACK, pk_att);
      write_coef(CSR_PEAK_RELEASE, pk_rel);
      write_coef(3'($urandom_range(CSR_UNMAPPED_FIRST, CSR_UNMAPPED_LAST)), 16'($urandom));
   endtask

   // block is idle once every frame is in and every level word is out
   task automatic drain();
      while (!(frames_accepted == frames_queued && level_words_due.size() == 0))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random phase content: runs of loud, quiet, extreme and lopsided frames,
   // so the levels climb and fall and both attack and release paths get used
   task automatic queue_random_frames(int count);
      int style;
      int run_left;
      style = 0;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            style = $urandom_range(0, 3);
            run_left = $urandom_range(1, 20);
         end
         run_left--;
         case (style)
            0: queue_frame(16'($urandom), 16'($urandom));
            1: queue_frame(pick_quiet(), pick_quiet());
            2: queue_frame(pick_extreme(), pick_extreme());
            default: begin
               if ($urandom_range(0, 1)) queue_frame(16'($urandom), pick_quiet());
               else queue_frame(pick_quiet(), 16'($urandom));
            end
         endcase
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: every level tracks its input exactly
      flow_mode = FLOW_FREE;
      queue_frame(16'h0000, 16'h0000);
      queue_frame(16'h7FFF, 16'h8000);
      queue_frame(16'h8000, 16'h7FFF);
      queue_frame(16'hFFFF, 16'h0001);
      queue_frame(16'h0001, 16'hFFFF);
      queue_frame(16'h7FFF, 16'h7FFF);
      queue_frame(16'h8000, 16'h8000);
      queue_frame(16'h0000, 16'h0000);
      queue_frame(16'h5555, 16'hAAAA);
      queue_frame(16'hAAAA, 16'h5555);
      drain();

      // fast attack, slow release: step up, hold, then fall away
      set_coefs(16'h2000, 16'hE000, 16'h0800, 16'hF800);
      repeat (3) queue_frame(16'h8000, 16'h0000);
      repeat (3) queue_frame(16'h0000, 16'h8000);
      queue_frame(16'h0064, 16'hFF9C);
      repeat (2) queue_frame(16'h7FFF, 16'h7FFF);
      repeat (3) queue_frame(16'h0000, 16'h0000);
      queue_frame(16'h8001, 16'h0001);
      queue_frame(16'hFFFF, 16'hFFFF);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            1: set_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            2: set_coefs(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
            3: set_coefs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
            default: set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
         endcase
         flow_mode = flow_mode_type'(p % 4);
         queue_random_frames(PHASE_FRAMES);
         drain();
      end

      if (error_count == 0 && level_words_due.size() == 0) begin
         $display("stereo_rms_peak_envelope: match");
      end else begin
         $display("stereo_rms_peak_envelope: mismatch");
      end
      $finish;
   end

endmodule
